// ----- hdl/tkms_pkg.sv -----
// ----------------------------------------------------------------------------
// tkms_pkg: shared types and constants for the top-k selector
// Value type, register widths, sequencer states and the cell command bundle.
// ----------------------------------------------------------------------------
package tkms_pkg;

    localparam int VALUE_W      = 32;
    localparam int CNT_W        = 5;    // keep_count / held_count port width
    localparam int MAX_KEEP_DEF = 16;
    localparam int KEEP_RESET   = 16;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } state_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic compare;  // latch lt/eq flags against the offered value
        logic insert;   // shift up above the insertion point
        logic replace;  // drop the minimum, shift down below the insertion point
    } cell_cmd_t;

endpackage

// ----- hdl/tkms_cell.sv -----
// ----------------------------------------------------------------------------
// tkms_cell: one slot of the sorted selector chain
// Holds one value, compares it with the offered value and moves data
// to or from its neighbors on insert and replace.
// ----------------------------------------------------------------------------
module tkms_cell (
    input  logic                clk,
    input  tkms_pkg::cell_cmd_t cmd,
    input  logic                valid,
    input  tkms_pkg::value_t    vin,
    input  tkms_pkg::value_t    lo_val,
    input  logic                lo_lt,
    input  tkms_pkg::value_t    hi_val,
    input  logic                hi_lt,
    output tkms_pkg::value_t    val_q,
    output tkms_pkg::value_t    val_nx,
    output logic                lt_q,
    output logic                eq_q
);
    import tkms_pkg::*;

    value_t val_reg;
    value_t val_next;
    logic   lt_reg;
    logic   eq_reg;

    always_comb
    begin
        val_next = val_reg;
        if (cmd.insert)
        begin
            // lower neighbor below the new value: the new value lands here
            if (!lt_reg)
            begin
                val_next = lo_lt ? vin : lo_val;
            end
        end
        else if (cmd.replace)
        begin
            if (lt_reg)
            begin
                val_next = hi_lt ? hi_val : vin;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        if (cmd.compare)
        begin
            lt_reg <= valid && (val_reg < vin);
            eq_reg <= valid && (val_reg == vin);
        end
    end

    assign val_q  = val_reg;
    assign val_nx = val_next;
    assign lt_q   = lt_reg;
    assign eq_q   = eq_reg;

endmodule

// ----- hdl/top_k_min_heap_selector.sv -----
// ----------------------------------------------------------------------------
// top_k_min_heap_selector: keeps the largest distinct values of a stream
// A chain of cells holds the kept values sorted ascending, so cell 0 is
// always the minimum (the k-th largest once the set is full).
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------
//   in      | sink      | in_valid / in_stall | value, clear
//   out     | source    | out_valid/out_stall | accepted, was_duplicate,
//           |           |                     | kth_largest, held_count,
//           |           |                     | full_res
//   cfg     | sink      | cfg_valid/cfg_ready | keep_count
//
// Each item passes through a compare cycle, where every cell latches
// its less-than and equal flags, and an update cycle, where the cells
// shift by one place toward or away from their neighbor. The next item
// can enter during the update cycle of the one before it, not earlier.
// The update cycle waits while a previous result is still stalled.
// Reset (rst_n, async) empties the set and sets keep_count to 16; no
// clearing pass is needed since only cells below the held count are read.
// A keep_count write also empties the set.
// ----------------------------------------------------------------------------
module top_k_min_heap_selector #(
    parameter int MAX_KEEP = tkms_pkg::MAX_KEEP_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  tkms_pkg::value_t               value,
    input  logic                           clear,
    // result channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           accepted,
    output logic                           was_duplicate,
    output tkms_pkg::value_t               kth_largest,
    output logic [tkms_pkg::CNT_W-1:0]     held_count,
    output logic                           full_res,
    // configuration
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tkms_pkg::CNT_W-1:0]     keep_count
);
    import tkms_pkg::*;

    localparam int CAP_W = $clog2(MAX_KEEP + 1);
    localparam int KW    = (CAP_W > CNT_W) ? CAP_W : CNT_W;

    state_t state_reg;
    state_t state_next;

    logic [CNT_W-1:0] keep_reg;
    logic [CAP_W-1:0] held_reg;
    logic [CAP_W-1:0] held_next;
    value_t           vin_reg;

    logic             out_valid_reg;
    logic             acc_reg;
    logic             dup_reg;
    value_t           kth_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             full_reg;

    logic [KW-1:0]    keep_ext;
    logic [KW-1:0]    cap_ext;
    logic [CAP_W-1:0] cap;

    logic             slot_free;
    logic             in_take;
    logic             cfg_take;
    logic             upd;
    logic             dup;
    logic             is_full;
    logic             do_ins;
    logic             do_rep;
    logic [CAP_W-1:0] held_upd;
    logic [KW-1:0]    held_upd_ext;

    cell_cmd_t        cmd;

    value_t           val_q  [MAX_KEEP];
    value_t           val_nx [MAX_KEEP];
    logic [MAX_KEEP-1:0] lt_q;
    logic [MAX_KEEP-1:0] eq_q;
    logic [MAX_KEEP-1:0] cell_valid;

    // capacity: zero acts as one, anything past the chain length is clamped
    always_comb
    begin
        keep_ext = KW'(keep_reg);
        if (keep_ext == '0)
        begin
            cap_ext = KW'(1);
        end
        else if (keep_ext > KW'(MAX_KEEP))
        begin
            cap_ext = KW'(MAX_KEEP);
        end
        else
        begin
            cap_ext = keep_ext;
        end
    end
    assign cap = cap_ext[CAP_W-1:0];

    assign slot_free = !out_valid_reg || !out_stall;
    assign in_take   = in_valid && !in_stall;
    assign cfg_take  = cfg_valid && cfg_ready;
    assign upd       = (state_reg == S_UPD) && slot_free;

    // decisions of the update cycle, from the flags latched in the compare cycle
    assign dup      = |eq_q;
    assign is_full  = (held_reg == cap);
    assign do_ins   = !dup && !is_full;
    assign do_rep   = !dup && is_full && lt_q[0];
    assign held_upd = held_reg + CAP_W'(do_ins);
    assign held_upd_ext = KW'(held_upd);

    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (slot_free)
                begin
                    state_next = in_take ? S_CMP : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer: outputs
    always_comb
    begin
        in_stall    = 1'b1;
        cfg_ready   = 1'b0;
        cmd.compare = 1'b0;
        cmd.insert  = 1'b0;
        cmd.replace = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall  = cfg_valid;
                cfg_ready = 1'b1;
            end
            S_CMP:
            begin
                cmd.compare = 1'b1;
            end
            S_UPD:
            begin
                // next item may enter as this one retires
                in_stall    = !slot_free || cfg_valid;
                cmd.insert  = slot_free && do_ins;
                cmd.replace = slot_free && do_rep;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // held count: config and clear empty the set, the update cycle may add one
    always_comb
    begin
        held_next = held_reg;
        if (cfg_take)
        begin
            held_next = '0;
        end
        else if (in_take && clear)
        begin
            held_next = '0;
        end
        else if (upd)
        begin
            held_next = held_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            keep_reg      <= CNT_W'(KEEP_RESET);
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
            if (cfg_take)
            begin
                keep_reg <= keep_count;
            end
            if (upd)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            vin_reg <= value;
        end
        if (upd)
        begin
            acc_reg  <= do_ins || do_rep;
            dup_reg  <= dup;
            kth_reg  <= (held_upd != '0) ? val_nx[0] : '0;
            cnt_reg  <= held_upd_ext[CNT_W-1:0];
            full_reg <= (held_upd == cap);
        end
    end

    // the cell chain; cell 0 holds the minimum
    for (genvar i = 0; i < MAX_KEEP; i++)
    begin : g_cell
        value_t lo_val;
        logic   lo_lt;
        value_t hi_val;
        logic   hi_lt;

        assign cell_valid[i] = CAP_W'(i) < held_reg;

        if (i == 0)
        begin : g_lo_end
            assign lo_val = vin_reg;
            assign lo_lt  = 1'b1;
        end
        else
        begin : g_lo
            assign lo_val = val_q[i-1];
            assign lo_lt  = lt_q[i-1];
        end

        if (i == MAX_KEEP - 1)
        begin : g_hi_end
            assign hi_val = vin_reg;
            assign hi_lt  = 1'b0;
        end
        else
        begin : g_hi
            assign hi_val = val_q[i+1];
            assign hi_lt  = lt_q[i+1];
        end

        tkms_cell u_cell (
            .clk    (clk),
            .cmd    (cmd),
            .valid  (cell_valid[i]),
            .vin    (vin_reg),
            .lo_val (lo_val),
            .lo_lt  (lo_lt),
            .hi_val (hi_val),
            .hi_lt  (hi_lt),
            .val_q  (val_q[i]),
            .val_nx (val_nx[i]),
            .lt_q   (lt_q[i]),
            .eq_q   (eq_q[i])
        );
    end

    assign out_valid     = out_valid_reg;
    assign accepted      = acc_reg;
    assign was_duplicate = dup_reg;
    assign kth_largest   = kth_reg;
    assign held_count    = cnt_reg;
    assign full_res      = full_reg;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    a_held_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= cap)
        else $error("held count above capacity");

    a_acc_not_dup: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && accepted |-> !was_duplicate)
        else $error("result both accepted and duplicate");

    a_cfg_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_take |=> held_reg == '0)
        else $error("config write did not empty the set");

    a_take_to_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> state_reg == S_CMP)
        else $error("transfer in did not start a compare cycle");

    a_rep_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.replace |-> held_reg == cap && !cmd.insert)
        else $error("replace issued on a set that is not full");

endmodule

// ----- tb/tb_top_k_min_heap_selector.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top_k_min_heap_selector: self-checking bench for the top-k selector
// Offers signed values, with an occasional clear, through the valid/stall
// input channel. The bench keeps its own copy of the kept set and predicts
// each result as the input transfer happens. A monitor then compares every
// result transfer with the oldest prediction. The keep_count register is
// written only while the block is idle. Its settings include the edge
// values 0, 1, 16, 17 and 31, and the traffic runs under several mixes of
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top_k_min_heap_selector;

    import tkms_pkg::*;

    localparam int CLK_HALF   = 5;
    localparam int KEEP_LIMIT = MAX_KEEP_DEF;

    // One predicted result transfer.
    typedef struct {
        logic               accepted;
        logic               duplicate;
        value_t             kth;
        logic [CNT_W-1:0]   count;
        logic               full;
    } selector_result_t;

    // ------------------------------------------------------------------
    // DUT signals. Every input has a known value from time zero.
    // ------------------------------------------------------------------
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    value_t             value = '0;
    logic               clear = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               accepted;
    logic               was_duplicate;
    value_t             kth_largest;
    logic [CNT_W-1:0]   held_count;
    logic               full_res;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CNT_W-1:0]   keep_count = CNT_W'(KEEP_RESET);

    // ------------------------------------------------------------------
    // Bench state: the predicted set, the expected result FIFO and the
    // gap and stall percentages of the current phase.
    // ------------------------------------------------------------------
    value_t             kept_values[$];
    int unsigned        kept_limit = KEEP_RESET;
    selector_result_t   pending_results[$];
    int unsigned        error_count = 0;
    int unsigned        send_gap_pct = 0;
    int unsigned        stall_pct = 0;

    top_k_min_heap_selector dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .value          (value),
        .clear          (clear),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .accepted       (accepted),
        .was_duplicate  (was_duplicate),
        .kth_largest    (kth_largest),
        .held_count     (held_count),
        .full_res       (full_res),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .keep_count     (keep_count)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Receiver back-pressure: one stall decision per cycle.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // A register value of 0 keeps one value. Anything above the store
    // depth keeps the whole store.
    function automatic int unsigned effective_limit(logic [CNT_W-1:0] k);
        if (k == 0)
            return 1;
        if (k > KEEP_LIMIT)
            return KEEP_LIMIT;
        return 32'(k);
    endfunction

    // Only the set of kept values matters at the outputs. Replacing the
    // root of a min-heap is the same as swapping out the smallest member.
    function automatic selector_result_t offer_to_set(value_t v, logic clr);
        selector_result_t r;
        int               low_idx;
        r.accepted  = 1'b0;
        r.duplicate = 1'b0;
        r.kth       = '0;
        if (clr)
            kept_values.delete();
        foreach (kept_values[i])
            if (kept_values[i] == v)
                r.duplicate = 1'b1;
        if (!r.duplicate) begin
            if (kept_values.size() < kept_limit) begin
                kept_values.push_back(v);
                r.accepted = 1'b1;
            end
            else begin
                low_idx = 0;
                foreach (kept_values[i])
                    if (kept_values[i] < kept_values[low_idx])
                        low_idx = i;
                // Only a value strictly above the minimum gets in.
                if (kept_values[low_idx] < v) begin
                    kept_values[low_idx] = v;
                    r.accepted = 1'b1;
                end
            end
        end
        // kth_largest is the true minimum, even before the set is full.
        if (kept_values.size() > 0) begin
            r.kth = kept_values[0];
            foreach (kept_values[i])
                if (kept_values[i] < r.kth)
                    r.kth = kept_values[i];
        end
        r.count = CNT_W'(kept_values.size());
        r.full  = (kept_values.size() == kept_limit);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result monitor: every result transfer is checked against the
    // oldest prediction.
    // ------------------------------------------------------------------
    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $realtime, name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        selector_result_t exp_r;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kth %0d count %0d",
                         $realtime, kth_largest, held_count);
                error_count++;
            end
            else begin
                exp_r = pending_results.pop_front();
                check_field("accepted", longint'(exp_r.accepted), longint'(accepted));
                check_field("was_duplicate", longint'(exp_r.duplicate),
                            longint'(was_duplicate));
                check_field("kth_largest", longint'(exp_r.kth), longint'(kth_largest));
                check_field("held_count", longint'(exp_r.count), longint'(held_count));
                check_field("full_res", longint'(exp_r.full), longint'(full_res));
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared driver tasks. All of them start and end at a rising edge.
    // ------------------------------------------------------------------

    // Offer one value. Valid stays high across back-to-back transfers.
    task automatic offer_value(value_t v, logic clr);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        clear    <= clr;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(offer_to_set(v, clr));
    endtask

    // Hold off the sender until every predicted result has arrived.
    // Each item always makes a result, so a short tail is enough.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write keep_count. Only called while the block is idle.
    task automatic write_keep_count(logic [CNT_W-1:0] k);
        wait_for_drain();
        cfg_valid  <= 1'b1;
        keep_count <= k;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        // Any write also empties the set.
        kept_limit = effective_limit(k);
        kept_values.delete();
    endtask

    // Mostly a narrow pool, so duplicates, drops and replacements are
    // common. The rest are full-width words and values near the extremes.
    function automatic value_t pick_value();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return value_t'($urandom_range(0, 40)) - 20;
        if (sel < 85)
            return value_t'($urandom);
        if (sel < 93)
            return 32'sh8000_0000 + value_t'($urandom_range(0, 3));
        return 32'sh7FFF_FFFF - value_t'($urandom_range(0, 3));
    endfunction

    task automatic run_traffic(int unsigned items, int unsigned gap_pct,
                               int unsigned hold_pct);
        send_gap_pct = gap_pct;
        stall_pct    = hold_pct;
        repeat (items) begin
            offer_value(pick_value(), ($urandom_range(0, 99) < 4));
            // Now and then let the pipeline empty out completely.
            if ($urandom_range(0, 99) < 2)
                wait_for_drain();
        end
    endtask

    // ------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------

    // Reset value of keep_count (16): extreme values, a duplicate, a clear
    // that comes with a value, and the minimum reported before the set
    // is full.
    task automatic test_reset_setting();
        send_gap_pct = 0;
        stall_pct    = 0;
        offer_value(32'sh8000_0000, 1'b0);
        offer_value(32'sh7FFF_FFFF, 1'b0);
        offer_value(0, 1'b0);
        offer_value(-1, 1'b0);
        offer_value(32'sh7FFF_FFFF, 1'b0);
        offer_value(1, 1'b1);
        offer_value(1, 1'b0);
    endtask

    // Small set: it fills, then takes a drop, a replacement of the
    // minimum and a replacement by the largest value.
    task automatic test_small_set();
        write_keep_count(CNT_W'(2));
        offer_value(5, 1'b0);
        offer_value(9, 1'b0);
        offer_value(5, 1'b0);
        offer_value(4, 1'b0);
        offer_value(7, 1'b0);
        offer_value(32'sh7FFF_FFFF, 1'b0);
    endtask

    // A keep_count of zero behaves as one.
    task automatic test_zero_keep();
        write_keep_count('0);
        offer_value(10, 1'b0);
        offer_value(10, 1'b0);
        offer_value(11, 1'b0);
        offer_value(8, 1'b0);
    endtask

    // Random traffic across the capacity range, out-of-range settings
    // included, under each gap and stall mix.
    task automatic test_random_traffic();
        write_keep_count(CNT_W'(16));
        run_traffic(100, 0, 0);
        write_keep_count(CNT_W'(4));
        run_traffic(80, 66, 0);
        write_keep_count(CNT_W'(31));
        run_traffic(80, 0, 66);
        write_keep_count(CNT_W'(1));
        run_traffic(60, 36, 36);
        write_keep_count(CNT_W'(17));
        run_traffic(30, 0, 0);
        write_keep_count(CNT_W'($urandom_range(2, 15)));
        run_traffic(40, 36, 36);
    endtask

    // The sender stops mid-stream until the pipeline is empty, then
    // carries on against the same set.
    task automatic test_drain_pause();
        write_keep_count('0);
        run_traffic(20, 36, 36);
        wait_for_drain();
        run_traffic(20, 0, 66);
        write_keep_count(CNT_W'(8));
        run_traffic(20, 66, 0);
        wait_for_drain();
        run_traffic(20, 0, 0);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_setting();
        test_small_set();
        test_zero_keep();
        test_random_traffic();
        test_drain_pause();

        wait_for_drain();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/tkms_pkg.sv
hdl/tkms_cell.sv
hdl/top_k_min_heap_selector.sv
tb/tb_top_k_min_heap_selector.sv
